[design/dagt_pkg.sv]
package dagt_pkg;

  localparam int MAX_NODES   = 16;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int PEND_W      = $clog2(MAX_NODES + 1);
  localparam int UCNT_W      = $clog2(MAX_NODES + 1);

  localparam int CFG_W       = 5;
  localparam int CMD_W       = 3;
  localparam int NODE_W      = 4;
  localparam int STATE_W     = 3;
  localparam int MASK_W      = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_EDGE   = 3'd1,
    CMD_ARM    = 3'd2,
    CMD_REPORT = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_e;

  typedef enum logic [STATE_W-1:0] {
    ST_WAITING = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_SUCCESS = 3'd3,
    ST_FAULT   = 3'd4
  } node_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_EDGE,
    OP_ARM,
    OP_REPORT
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ARM,
    S_CASC,
    S_WAIT,
    S_RESULT
  } ctrl_state_e;

  // broadcast command to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  src;
    node_state_e       state;
    logic              arm_first;
    logic              arm_last;
  } cell_cmd_t;

  // completion token walking down the cell row
  typedef struct packed {
    logic                  valid;
    logic [IDX_W-1:0]      src;
    logic [MAX_NODES-1:0]  fault_vec;
    logic [MAX_NODES-1:0]  work;
    logic [UCNT_W-1:0]     ucnt;
    logic                  fault_seen;
  } cascade_pkt_t;

endpackage

[design/dagt_cell.sv]
module dagt_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [dagt_pkg::IDX_W-1:0]      cell_idx_i,
  input  logic [dagt_pkg::MAX_NODES-1:0]  live_i,
  input  dagt_pkg::cell_cmd_t             cmd_i,
  input  dagt_pkg::cascade_pkt_t          pkt_i,
  output dagt_pkg::cascade_pkt_t          pkt_o,
  output dagt_pkg::node_state_e           state_o
);
  import dagt_pkg::*;

  logic [MAX_NODES-1:0] pred_q, pred_d;
  logic [PEND_W-1:0]    pend_q, pend_d;
  node_state_e          state_q, state_d;
  cascade_pkt_t         pkt_q, pkt_d;

  logic                 self_live;
  logic [PEND_W-1:0]    arm_sum;
  logic [PEND_W-1:0]    pend_dec;

  assign self_live = live_i[cell_idx_i];
  assign arm_sum   = (cmd_i.arm_first ? '0 : pend_q)
                   + PEND_W'(pred_q[cmd_i.src] & live_i[cmd_i.src]);
  assign pend_dec  = pend_q - PEND_W'(1);

  always_comb begin
    pred_d  = pred_q;
    pend_d  = pend_q;
    state_d = state_q;
    pkt_d   = pkt_i;

    unique case (cmd_i.op)
      OP_CLEAR: begin
        pred_d  = '0;
        pend_d  = '0;
        state_d = ST_WAITING;
      end
      OP_EDGE: begin
        if (cmd_i.sel == cell_idx_i) begin
          pred_d[cmd_i.src] = 1'b1;
        end
      end
      OP_ARM: begin
        if (self_live) begin
          pend_d = arm_sum;
          if (cmd_i.arm_last) begin
            state_d = (arm_sum == '0) ? ST_READY : ST_WAITING;
          end
        end
      end
      OP_REPORT: begin
        if (cmd_i.sel == cell_idx_i) begin
          state_d = cmd_i.state;
        end
      end
      OP_NONE: ;
      default: ;
    endcase

    if (pkt_i.valid && self_live && pred_q[pkt_i.src] && (pend_q != '0)) begin
      pend_d = pend_dec;
      if ((pend_dec == '0) && (state_q == ST_WAITING)) begin
        if ((pred_q & live_i & pkt_i.fault_vec) != '0) begin
          state_d                    = ST_FAULT;
          pkt_d.fault_vec[cell_idx_i] = 1'b1;
          pkt_d.work[cell_idx_i]      = 1'b1;
          pkt_d.fault_seen           = 1'b1;
          if (pkt_i.ucnt != '0) begin
            pkt_d.ucnt = pkt_i.ucnt - UCNT_W'(1);
          end
        end else begin
          state_d = ST_READY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q  <= '0;
      pend_q  <= '0;
      state_q <= ST_WAITING;
      pkt_q   <= '0;
    end else begin
      pred_q  <= pred_d;
      pend_q  <= pend_d;
      state_q <= state_d;
      pkt_q   <= pkt_d;
    end
  end

  assign pkt_o   = pkt_q;
  assign state_o = state_q;

endmodule

[design/dag_dependency_tracker_top.sv]
// Task-graph dependency tracker using in-degree counting. Each input item
// carries a command in tuser (clear, add edge, arm, report state, query) and
// returns exactly one result item: a mask of the nodes in use whose state
// equals the item's node_state, plus all-done and any-fault flags. Every node
// is a cell in a row holding its predecessor mask, remaining-predecessor count
// and state. Clear, add edge and query pass from the execute state to the
// result state. Arm broadcasts one predecessor index per cycle, from 0 to
// MAX_NODES - 1. A success or fault report processes every completion in turn,
// the reported node and each node that faults in the cascade, and each
// completion walks once down the cell row. The next item is taken while a
// result waits in the output register. No clearing pass follows reset.
module dag_dependency_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] node, [7:4] other_node, [10:8] node_state, [15:11] zero
  input  logic [dagt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] cmd
  input  logic [dagt_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] match_mask, [16] all_done, [17] any_fault, [23:18] zero
  output logic [dagt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [dagt_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import dagt_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [CFG_W-1:0]     node_count_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [NODE_W-1:0]    node_q;
  logic [NODE_W-1:0]    other_q;
  logic [STATE_W-1:0]   st_q;
  logic [IDX_W-1:0]     j_q, j_d;
  logic [MAX_NODES-1:0] wl_q, wl_d;
  logic [UCNT_W-1:0]    ucnt_q, ucnt_d;
  logic                 fault_q, fault_d;
  logic                 out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                 out_load;

  logic [MAX_NODES-1:0] live;
  logic [UCNT_W-1:0]    cnt_eff;
  logic                 node_ok, other_ok, st_ok;
  logic [IDX_W-1:0]     node_idx, other_idx;
  logic [MAX_NODES-1:0] low_oh;
  logic [IDX_W-1:0]     low_idx;
  logic [MAX_NODES-1:0] fault_now;
  logic [MASK_W-1:0]    match;
  logic                 arm_last;

  cell_cmd_t            ccmd;
  cascade_pkt_t         launch;
  cascade_pkt_t         chain [MAX_NODES+1];
  node_state_e          cell_state [MAX_NODES];

  assign cnt_eff = (32'(node_count_q) > MAX_NODES) ? UCNT_W'(MAX_NODES)
                                                   : UCNT_W'(node_count_q);
  assign node_ok   = 32'(node_q) < 32'(cnt_eff);
  assign other_ok  = 32'(other_q) < 32'(cnt_eff);
  assign st_ok     = st_q <= STATE_W'(ST_FAULT);
  assign node_idx  = IDX_W'(node_q);
  assign other_idx = IDX_W'(other_q);
  assign low_oh    = wl_q & (~wl_q + MAX_NODES'(1));
  assign arm_last  = (j_q == IDX_W'(MAX_NODES - 1));
  assign chain[0]  = launch;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cells
    assign live[g]      = 32'(node_count_q) > g;
    assign fault_now[g] = (cell_state[g] == ST_FAULT);

    dagt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .live_i     (live),
      .cmd_i      (ccmd),
      .pkt_i      (chain[g]),
      .pkt_o      (chain[g+1]),
      .state_o    (cell_state[g])
    );
  end

  for (genvar g = 0; g < MASK_W; g++) begin : g_match
    if (g < MAX_NODES) begin : g_used
      assign match[g] = live[g] && st_ok && (STATE_W'(cell_state[g]) == st_q);
    end else begin : g_none
      assign match[g] = 1'b0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    wl_d     = wl_q;
    ucnt_d   = ucnt_q;
    fault_d  = fault_q;
    out_load = 1'b0;
    ccmd     = '0;
    ccmd.op  = OP_NONE;
    launch   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
        unique case (cmd_q)
          CMD_CLEAR: begin
            ccmd.op = OP_CLEAR;
            wl_d    = '0;
            ucnt_d  = '0;
            fault_d = 1'b0;
          end
          CMD_EDGE: begin
            if (node_ok && other_ok) begin
              ccmd.op  = OP_EDGE;
              ccmd.sel = other_idx;
              ccmd.src = node_idx;
            end
          end
          CMD_ARM: begin
            j_d     = '0;
            state_d = S_ARM;
          end
          CMD_REPORT: begin
            if (node_ok && st_ok) begin
              ccmd.op    = OP_REPORT;
              ccmd.sel   = node_idx;
              ccmd.state = node_state_e'(st_q);
              if (st_q == STATE_W'(ST_FAULT)) begin
                fault_d = 1'b1;
              end
              if ((st_q == STATE_W'(ST_SUCCESS)) || (st_q == STATE_W'(ST_FAULT))) begin
                if (ucnt_q != '0) begin
                  ucnt_d = ucnt_q - UCNT_W'(1);
                end
                wl_d[node_idx] = 1'b1;
                state_d        = S_CASC;
              end
            end
          end
          CMD_QUERY: ;
          default: ;
        endcase
      end
      S_ARM: begin
        ccmd.op        = OP_ARM;
        ccmd.src       = j_q;
        ccmd.arm_first = (j_q == '0);
        ccmd.arm_last  = arm_last;
        j_d            = j_q + IDX_W'(1);
        if (arm_last) begin
          ucnt_d  = cnt_eff;
          fault_d = 1'b0;
          wl_d    = '0;
          state_d = S_RESULT;
        end
      end
      S_CASC: begin
        if (wl_q == '0) begin
          state_d = S_RESULT;
        end else begin
          launch.valid      = 1'b1;
          launch.src        = low_idx;
          launch.fault_vec  = fault_now;
          launch.work       = wl_q & ~low_oh;
          launch.ucnt       = ucnt_q;
          launch.fault_seen = fault_q;
          state_d           = S_WAIT;
        end
      end
      S_WAIT: begin
        if (chain[MAX_NODES].valid) begin
          wl_d    = chain[MAX_NODES].work;
          ucnt_d  = chain[MAX_NODES].ucnt;
          fault_d = chain[MAX_NODES].fault_seen;
          state_d = S_CASC;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= CFG_W'(16);
      j_q          <= '0;
      wl_q         <= '0;
      ucnt_q       <= '0;
      fault_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      wl_q    <= wl_d;
      ucnt_q  <= ucnt_d;
      fault_q <= fault_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q   <= s_axis_tuser;
      node_q  <= s_axis_tdata[3:0];
      other_q <= s_axis_tdata[7:4];
      st_q    <= s_axis_tdata[10:8];
    end
    if (out_load) begin
      out_data_q <= {6'b0, fault_q, (ucnt_q == '0), match};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_chain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_NODES].valid |-> (state_q == S_WAIT))
    else $error("completion token left the cell row outside of a wait");

  a_idle_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (wl_q == '0))
    else $error("pending completions left over between items");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESULT) && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result not presented after leaving result state");

endmodule
